FILE: rtl/core/kpc_pkg.sv
// Shared constants, codes and types for the key position calibrator.
package kpc_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int FRAC_BITS   = 12;
    localparam int PRESS_LEN   = 8;
    localparam int RING_LEN    = 64;
    localparam int RING_AW     = $clog2(RING_LEN);
    localparam int FILL_W      = $clog2(RING_LEN + 1);
    localparam int SUM_W       = SAMPLE_BITS + RING_AW;
    localparam int DVD_W       = SAMPLE_BITS + FRAC_BITS;
    localparam int DVS_W       = SAMPLE_BITS;
    localparam int STEP_W      = $clog2(DVD_W + 1);
    localparam int POS_W       = 14;

    localparam int ONE    = 1 << FRAC_BITS;
    localparam int POS_LO = ONE / 2;
    localparam int POS_HI = (ONE * 12) / 10;

    typedef enum logic [2:0] {
        OP_SAMPLE = 3'd0,
        OP_START  = 3'd1,
        OP_FINISH = 3'd2,
        OP_ABORT  = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_UPDATE = 3'd5
    } op_t;

    localparam logic [1:0] ST_NOT         = 2'd0;
    localparam logic [1:0] ST_CALIBRATING = 2'd1;
    localparam logic [1:0] ST_CALIBRATED  = 2'd2;

    typedef struct packed {
        logic               start;
        logic [DVD_W-1:0]   dividend;
        logic [DVS_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DVD_W-1:0]   quotient;
    } div_rsp_t;

endpackage

FILE: rtl/core/kpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kpc_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/kpc_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
module kpc_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  kpc_pkg::div_req_t req,
    output kpc_pkg::div_rsp_t rsp
);
    import kpc_pkg::*;

    logic [DVD_W-1:0]  q_reg;
    logic [DVS_W:0]    rem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              done_reg;

    logic [DVS_W:0]    rem_shift;
    logic [DVS_W+1:0]  diff;

    always_comb begin
        rem_shift = {rem_reg[DVS_W-1:0], q_reg[DVD_W-1]};
        diff      = {1'b0, rem_shift} - {2'b00, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                q_reg   <= req.dividend;
                rem_reg <= '0;
                dvs_reg <= req.divisor;
                cnt_reg <= STEP_W'(DVD_W);
            end else if (cnt_reg != '0) begin
                if (!diff[DVS_W+1]) begin
                    rem_reg <= diff[DVS_W:0];
                    q_reg   <= {q_reg[DVD_W-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_shift;
                    q_reg   <= {q_reg[DVD_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

FILE: rtl/core/key_position_calibrator_top.sv
// Key position calibrator top level: request handling, sample ring and calibration state.
//
// The work per request is set by the 24-step serial divider and by the sample ring,
// read one entry per cycle. Start, abort, clear and ignored requests go straight
// to the result state. A sample while calibrated runs one divide. A sample while
// calibrating goes straight to the result state until eight samples are held, then
// runs eight ring reads plus a divide. Finish and update-rest with enough samples
// read every held entry, at most 64 with a full ring, then divide. A new request is
// taken while the previous result still waits in the output register.
module key_position_calibrator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] raw_value, rest zero
    input  logic [2:0]  s_tuser,   // [2:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [13:0] position, rest zero
    output logic [3:0]  m_tuser,   // [0] position_valid, [1] finish_ok, [3:2] calib_status
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [11:0] cfg_wdata
);
    import kpc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SUM,
        S_DIV,
        S_RESULT
    } state_t;

    typedef enum logic [1:0] {
        M_POS,
        M_AVG,
        M_FIN,
        M_UPD
    } mode_t;

    state_t state_reg;
    mode_t  mode_reg;

    logic                   pgd_reg;
    logic [SAMPLE_BITS-1:0] min_range_reg;

    logic [1:0]             cal_reg;
    logic [1:0]             prev_reg;
    logic [SAMPLE_BITS-1:0] rest_reg;
    logic                   rest_valid_reg;
    logic [SAMPLE_BITS-1:0] press_reg;
    logic                   press_valid_reg;
    logic [SAMPLE_BITS-1:0] ext_reg;
    logic                   ext_valid_reg;
    logic [RING_AW-1:0]     head_reg;
    logic [FILL_W-1:0]      fill_reg;

    logic [RING_AW-1:0]     ptr_reg;
    logic [FILL_W-1:0]      issue_reg;
    logic [FILL_W-1:0]      count_reg;
    logic                   pend_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic                   neg_reg;

    logic [POS_W-1:0]       res_pos_reg;
    logic                   res_pvalid_reg;
    logic                   res_fin_reg;

    logic                   m_tvalid_reg;
    logic [POS_W-1:0]       m_pos_reg;
    logic                   m_pvalid_reg;
    logic                   m_fin_reg;
    logic [1:0]             m_status_reg;

    div_req_t               div_req_reg;
    div_rsp_t               div_rsp;

    logic                   accept;
    op_t                    op;
    logic [SAMPLE_BITS-1:0] raw;
    logic                   ring_we;
    logic [SAMPLE_BITS-1:0] ring_rdata;
    logic [1:0]             abort_st;
    logic [FILL_W-1:0]      fill_inc;
    logic [SAMPLE_BITS:0]   raw_diff;
    logic [SAMPLE_BITS:0]   den_diff;
    logic [SAMPLE_BITS-1:0] raw_mag;
    logic [SAMPLE_BITS-1:0] den_mag;
    logic                   pos_ok;
    logic [SAMPLE_BITS-1:0] qv;
    logic [SAMPLE_BITS:0]   ext_diff;
    logic [SAMPLE_BITS-1:0] ext_mag;
    logic                   better;
    logic [POS_W-1:0]       clip_mag;
    logic                   out_free;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign op       = op_t'(s_tuser);
    assign raw      = s_tdata[SAMPLE_BITS-1:0];
    assign ring_we  = accept && (op == OP_SAMPLE) && (cal_reg == ST_CALIBRATING);
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        abort_st = (prev_reg == ST_CALIBRATED) ? ST_CALIBRATED : ST_NOT;
        fill_inc = (fill_reg == FILL_W'(RING_LEN)) ? fill_reg : fill_reg + 1'b1;
        raw_diff = {1'b0, raw} - {1'b0, rest_reg};
        den_diff = {1'b0, press_reg} - {1'b0, rest_reg};
        raw_mag  = raw_diff[SAMPLE_BITS] ? SAMPLE_BITS'(-raw_diff) : raw_diff[SAMPLE_BITS-1:0];
        den_mag  = den_diff[SAMPLE_BITS] ? SAMPLE_BITS'(-den_diff) : den_diff[SAMPLE_BITS-1:0];
        pos_ok   = rest_valid_reg && press_valid_reg && (press_reg != rest_reg);
        qv       = div_rsp.quotient[SAMPLE_BITS-1:0];
        ext_diff = {1'b0, ext_reg} - {1'b0, qv};
        ext_mag  = ext_diff[SAMPLE_BITS] ? SAMPLE_BITS'(-ext_diff) : ext_diff[SAMPLE_BITS-1:0];
        better   = pgd_reg ? (qv < ext_reg) : (qv > ext_reg);
        if (neg_reg) begin
            clip_mag = (div_rsp.quotient > DVD_W'(POS_LO)) ? POS_W'(POS_LO)
                                                           : div_rsp.quotient[POS_W-1:0];
        end else begin
            clip_mag = (div_rsp.quotient > DVD_W'(POS_HI)) ? POS_W'(POS_HI)
                                                           : div_rsp.quotient[POS_W-1:0];
        end
    end

    kpc_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(RING_LEN)
    ) u_ring (
        .aclk (aclk),
        .we   (ring_we),
        .waddr(head_reg),
        .wdata(raw),
        .raddr(ptr_reg),
        .rdata(ring_rdata)
    );

    kpc_div u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (div_req_reg),
        .rsp    (div_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            mode_reg        <= M_POS;
            pgd_reg         <= 1'b0;
            min_range_reg   <= SAMPLE_BITS'(64);
            cal_reg         <= ST_NOT;
            prev_reg        <= ST_NOT;
            rest_valid_reg  <= 1'b0;
            press_valid_reg <= 1'b0;
            ext_valid_reg   <= 1'b0;
            head_reg        <= '0;
            fill_reg        <= '0;
            pend_reg        <= 1'b0;
            issue_reg       <= '0;
            div_req_reg     <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            div_req_reg.start <= 1'b0;
            if (cfg_we) begin
                if (cfg_index) begin
                    min_range_reg <= cfg_wdata;
                end else begin
                    pgd_reg <= cfg_wdata[0];
                end
            end
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        res_pos_reg    <= '0;
                        res_pvalid_reg <= 1'b0;
                        res_fin_reg    <= 1'b0;
                        state_reg      <= S_RESULT;
                        case (op) inside
                            OP_SAMPLE: begin
                                if (cal_reg == ST_CALIBRATED && pos_ok) begin
                                    neg_reg  <= raw_diff[SAMPLE_BITS] ^ den_diff[SAMPLE_BITS];
                                    mode_reg <= M_POS;
                                    div_req_reg.start    <= 1'b1;
                                    div_req_reg.dividend <= {raw_mag, FRAC_BITS'(0)};
                                    div_req_reg.divisor  <= den_mag;
                                    state_reg <= S_DIV;
                                end else if (cal_reg == ST_CALIBRATING) begin
                                    head_reg <= head_reg + 1'b1;
                                    fill_reg <= fill_inc;
                                    if (fill_inc >= FILL_W'(PRESS_LEN)) begin
                                        mode_reg  <= M_AVG;
                                        ptr_reg   <= head_reg;
                                        issue_reg <= FILL_W'(PRESS_LEN);
                                        count_reg <= FILL_W'(PRESS_LEN);
                                        sum_reg   <= '0;
                                        state_reg <= S_SUM;
                                    end
                                end
                            end
                            OP_START: begin
                                prev_reg       <= (cal_reg == ST_CALIBRATING) ? abort_st
                                                                              : cal_reg;
                                cal_reg        <= ST_CALIBRATING;
                                rest_valid_reg <= 1'b0;
                                head_reg       <= '0;
                                fill_reg       <= '0;
                                ext_valid_reg  <= 1'b0;
                            end
                            OP_FINISH, OP_UPDATE: begin
                                if (fill_reg >= FILL_W'(PRESS_LEN)) begin
                                    mode_reg  <= (op == OP_FINISH) ? M_FIN : M_UPD;
                                    ptr_reg   <= head_reg - 1'b1;
                                    issue_reg <= fill_reg;
                                    count_reg <= fill_reg;
                                    sum_reg   <= '0;
                                    state_reg <= S_SUM;
                                end else if (op == OP_UPDATE || cal_reg == ST_CALIBRATING) begin
                                    prev_reg      <= cal_reg;
                                    cal_reg       <= abort_st;
                                    head_reg      <= '0;
                                    fill_reg      <= '0;
                                    ext_valid_reg <= 1'b0;
                                end
                            end
                            OP_ABORT: begin
                                prev_reg      <= cal_reg;
                                cal_reg       <= abort_st;
                                head_reg      <= '0;
                                fill_reg      <= '0;
                                ext_valid_reg <= 1'b0;
                            end
                            OP_CLEAR: begin
                                prev_reg      <= ST_NOT;
                                cal_reg       <= ST_NOT;
                                head_reg      <= '0;
                                fill_reg      <= '0;
                                ext_valid_reg <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SUM: begin
                    if (issue_reg != '0) begin
                        ptr_reg   <= ptr_reg - 1'b1;
                        issue_reg <= issue_reg - 1'b1;
                        pend_reg  <= 1'b1;
                    end else begin
                        pend_reg <= 1'b0;
                    end
                    if (pend_reg) begin
                        sum_reg <= sum_reg + SUM_W'(ring_rdata);
                    end
                    if (issue_reg == '0 && !pend_reg) begin
                        div_req_reg.start    <= 1'b1;
                        div_req_reg.dividend <= DVD_W'(sum_reg);
                        div_req_reg.divisor  <= DVS_W'(count_reg);
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        state_reg <= S_RESULT;
                        unique case (mode_reg)
                            M_POS: begin
                                res_pos_reg    <= neg_reg ? POS_W'(-clip_mag) : clip_mag;
                                res_pvalid_reg <= 1'b1;
                            end
                            M_AVG: begin
                                if (!ext_valid_reg || better) begin
                                    ext_reg       <= qv;
                                    ext_valid_reg <= 1'b1;
                                end
                            end
                            M_FIN: begin
                                if (ext_valid_reg && ext_mag >= min_range_reg) begin
                                    rest_reg        <= qv;
                                    rest_valid_reg  <= 1'b1;
                                    press_reg       <= ext_reg;
                                    press_valid_reg <= 1'b1;
                                    prev_reg        <= cal_reg;
                                    cal_reg         <= ST_CALIBRATED;
                                    res_fin_reg     <= 1'b1;
                                end else begin
                                    prev_reg <= cal_reg;
                                    cal_reg  <= abort_st;
                                end
                                head_reg      <= '0;
                                fill_reg      <= '0;
                                ext_valid_reg <= 1'b0;
                            end
                            M_UPD: begin
                                rest_reg       <= qv;
                                rest_valid_reg <= 1'b1;
                                prev_reg       <= cal_reg;
                                cal_reg        <= abort_st;
                                head_reg       <= '0;
                                fill_reg       <= '0;
                                ext_valid_reg  <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_RESULT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_pos_reg    <= res_pos_reg;
                        m_pvalid_reg <= res_pvalid_reg;
                        m_fin_reg    <= res_fin_reg;
                        m_status_reg <= cal_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_pos_reg};
    assign m_tuser  = {m_status_reg, m_fin_reg, m_pvalid_reg};

    // ring holds samples only during a calibration session
    a_fill_only_calibrating: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg != '0) |-> (cal_reg == ST_CALIBRATING))
        else $error("ring not empty outside calibration");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(RING_LEN))
        else $error("ring fill beyond depth");

    a_extreme_needs_samples: assert property (@(posedge aclk) disable iff (!aresetn)
        ext_valid_reg |-> (fill_reg >= FILL_W'(PRESS_LEN)))
        else $error("extreme valid without enough samples");

    a_press_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        press_valid_reg |=> press_valid_reg)
        else $error("press endpoint lost");

endmodule
